>>> rtl/mts_pkg.sv
package mts_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int MAX_TASKS  = 16;

  localparam int LVL_W   = $clog2(NUM_LEVELS);
  localparam int TASK_W  = $clog2(MAX_TASKS);
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);
  localparam int ADDR_W  = LVL_W + TASK_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int OP_W    = 2;
  localparam int ID_W    = 4;
  localparam int OUT_LVL_W = 2;
  localparam int SLICE_W = 11;
  localparam int TICK_W  = 32;
  localparam int QUANT_W = 8;

  localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd10;
  localparam logic [SLICE_W-1:0] SLICE_MAX   = 11'h7FF;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_YIELD = 2'd1;
  localparam logic [OP_W-1:0] OP_ADMIT = 2'd2;

  typedef struct packed {
    logic exec;
    logic rd;
    logic ld;
    logic load_out;
  } cmd_t;

  // Slices granted at a level: base shifted left by the level, saturating.
  function automatic logic [SLICE_W-1:0] quantum(input logic [QUANT_W-1:0] base,
                                                 input logic [LVL_W-1:0] lvl);
    logic [QUANT_W+6:0] wide;
    wide = {7'd0, base} << lvl;
    if (wide > {{(QUANT_W-4){1'b0}}, SLICE_MAX}) begin
      return SLICE_MAX;
    end
    return wide[SLICE_W-1:0];
  endfunction

endpackage

>>> rtl/mts_ctrl.sv
module mts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mts_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.exec   = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.rd     = (state_q == ST_READ);
  assign cmd_o.ld     = (state_q == ST_LOAD);
  assign cmd_o.load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/mts_dp.sv
module mts_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mts_pkg::cmd_t                 cmd_i,
  input  logic                          cfg_we_i,
  input  logic [mts_pkg::QUANT_W-1:0]   cfg_quantum_i,
  input  logic [mts_pkg::OP_W-1:0]      opcode_i,
  input  logic [mts_pkg::ID_W-1:0]      task_id_i,
  output logic [mts_pkg::ID_W-1:0]      running_task_o,
  output logic [mts_pkg::OUT_LVL_W-1:0] running_level_o,
  output logic [mts_pkg::SLICE_W-1:0]   slices_left_o,
  output logic [mts_pkg::TICK_W-1:0]    task_ticks_o,
  output logic                          switched_o,
  output logic                          idle_o,
  output logic                          admit_error_o
);

  localparam int NL  = mts_pkg::NUM_LEVELS;
  localparam int NT  = mts_pkg::MAX_TASKS;
  localparam int LW  = mts_pkg::LVL_W;
  localparam int TW  = mts_pkg::TASK_W;
  localparam int CW  = mts_pkg::CNT_W;
  localparam int SW  = mts_pkg::SLICE_W;
  localparam int KW  = mts_pkg::TICK_W;

  // Control state.
  logic [TW-1:0] head_q  [NL];
  logic [TW-1:0] head_d  [NL];
  logic [CW-1:0] count_q [NL];
  logic [CW-1:0] count_d [NL];
  logic [NT-1:0] active_q;
  logic [TW-1:0] cur_q;
  logic [mts_pkg::QUANT_W-1:0] base_q;

  // Per-task records, only ever read for admitted tasks.
  logic [LW-1:0] level_q [NT];
  logic [SW-1:0] slices_q [NT];
  logic [KW-1:0] ticks_q [NT];

  // Ring storage of all level FIFOs.
  logic [TW-1:0] mem_q [mts_pkg::MEM_DEPTH];
  logic [TW-1:0] rdata_q;

  // Per-item bookkeeping.
  logic          was_busy_q;
  logic [TW-1:0] prev_q;
  logic          err_q;
  logic          repick_q;

  // Execute-cycle signals.
  logic          busy;
  logic [TW-1:0] c;
  logic [LW-1:0] lc;
  logic [LW-1:0] nl;
  logic [SW-1:0] s_dec;
  logic          expire;
  logic [TW-1:0] id_idx;
  logic          id_ok;
  logic          do_drop;
  logic          do_push;
  logic [LW-1:0] drop_lvl;
  logic [LW-1:0] push_lvl;
  logic [TW-1:0] push_id;
  logic [TW:0]   pos_sum;
  logic [TW-1:0] push_pos;
  logic          repick;
  logic          err;
  logic [TW-1:0] w_idx;
  logic          we_level;
  logic          we_slices;
  logic          we_ticks;
  logic          set_active;
  logic [LW-1:0] w_level;
  logic [SW-1:0] w_slices;
  logic [KW-1:0] w_ticks;
  logic [LW-1:0] pick_lvl;

  always_comb begin
    busy = 1'b0;
    for (int l = 0; l < NL; l++) begin
      if (count_q[l] != '0) begin
        busy = 1'b1;
      end
    end
  end

  assign c      = cur_q;
  assign lc     = level_q[c];
  assign nl     = (lc == LW'(NL - 1)) ? lc : lc + LW'(1);
  assign s_dec  = (slices_q[c] != '0) ? slices_q[c] - SW'(1) : '0;
  assign expire = (s_dec == '0);
  assign id_idx = TW'(task_id_i);
  assign id_ok  = (32'(task_id_i) < NT) && !active_q[id_idx];

  always_comb begin
    do_drop    = 1'b0;
    do_push    = 1'b0;
    drop_lvl   = lc;
    push_lvl   = lc;
    push_id    = c;
    repick     = 1'b0;
    err        = 1'b0;
    w_idx      = c;
    we_level   = 1'b0;
    we_slices  = 1'b0;
    we_ticks   = 1'b0;
    set_active = 1'b0;
    w_level    = nl;
    w_slices   = s_dec;
    w_ticks    = ticks_q[c] + KW'(1);
    case (opcode_i)
      mts_pkg::OP_TICK: begin
        if (busy) begin
          we_ticks  = 1'b1;
          we_slices = 1'b1;
          if (expire) begin
            do_drop  = 1'b1;
            do_push  = 1'b1;
            push_lvl = nl;
            we_level = 1'b1;
            w_slices = mts_pkg::quantum(base_q, nl);
            repick   = 1'b1;
          end
        end
      end
      mts_pkg::OP_YIELD: begin
        if (busy) begin
          do_drop = 1'b1;
          do_push = 1'b1;
          repick  = 1'b1;
        end
      end
      mts_pkg::OP_ADMIT: begin
        if (!id_ok) begin
          err = 1'b1;
        end else begin
          w_idx      = id_idx;
          set_active = 1'b1;
          we_level   = 1'b1;
          we_slices  = 1'b1;
          we_ticks   = 1'b1;
          w_level    = '0;
          w_slices   = mts_pkg::quantum(base_q, '0);
          w_ticks    = '0;
          do_push    = 1'b1;
          push_lvl   = '0;
          push_id    = id_idx;
          repick     = !busy;
        end
      end
      default: ;
    endcase
  end

  // Tail slot from the counts before this item: when the task drops from and
  // rejoins the same level, head moves up by one and count down by one.
  assign pos_sum  = {1'b0, head_q[push_lvl]} + (TW+1)'(count_q[push_lvl]);
  assign push_pos = (pos_sum >= (TW+1)'(NT)) ? TW'(pos_sum - (TW+1)'(NT)) : TW'(pos_sum);

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      head_d[l]  = head_q[l];
      count_d[l] = count_q[l];
      if (cmd_i.exec && do_drop && (drop_lvl == LW'(l))) begin
        head_d[l]  = (head_q[l] == TW'(NT - 1)) ? '0 : head_q[l] + TW'(1);
        count_d[l] = count_d[l] - CW'(1);
      end
      if (cmd_i.exec && do_push && (push_lvl == LW'(l))) begin
        count_d[l] = count_d[l] + CW'(1);
      end
    end
  end

  always_comb begin
    pick_lvl = '0;
    for (int l = NL - 1; l >= 0; l--) begin
      if (count_q[l] != '0) begin
        pick_lvl = LW'(l);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NL; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
      active_q <= '0;
      cur_q    <= '0;
      base_q   <= mts_pkg::QUANT_RESET;
    end else begin
      for (int l = 0; l < NL; l++) begin
        head_q[l]  <= head_d[l];
        count_q[l] <= count_d[l];
      end
      if (cmd_i.exec && set_active) begin
        active_q[w_idx] <= 1'b1;
      end
      if (cmd_i.ld && repick_q) begin
        cur_q <= rdata_q;
      end
      if (cfg_we_i) begin
        base_q <= cfg_quantum_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (we_level) begin
        level_q[w_idx] <= w_level;
      end
      if (we_slices) begin
        slices_q[w_idx] <= w_slices;
      end
      if (we_ticks) begin
        ticks_q[w_idx] <= w_ticks;
      end
      was_busy_q <= busy;
      prev_q     <= cur_q;
      err_q      <= err;
      repick_q   <= repick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_push) begin
      mem_q[{push_lvl, push_pos}] <= push_id;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[{pick_lvl, head_q[pick_lvl]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      admit_error_o <= err_q;
      if (busy) begin
        running_task_o  <= mts_pkg::ID_W'(cur_q);
        running_level_o <= mts_pkg::OUT_LVL_W'(level_q[cur_q]);
        slices_left_o   <= slices_q[cur_q];
        task_ticks_o    <= ticks_q[cur_q];
        switched_o      <= !was_busy_q || (cur_q != prev_q);
        idle_o          <= 1'b0;
      end else begin
        running_task_o  <= '0;
        running_level_o <= '0;
        slices_left_o   <= '0;
        task_ticks_o    <= '0;
        switched_o      <= 1'b0;
        idle_o          <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/mlfq_task_scheduler_top.sv
// Channel | Direction | Handshake              | Payload
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_quantum_i
// in      | in        | in_valid_i/in_ready_o   | opcode_i, task_id_i
// out     | out       | out_valid_o/out_ready_i | running_task_o .. admit_error_o
//
// Each item goes through, in order: the queue update at the accepting edge,
// the read of the picked level's head from the queue memory, loading the
// running task, and the result register. One item is in flight at a time.
// A waiting result stalls only the last step; the next item is accepted once
// the result register has been loaded. Reset clears all queues and the active
// set and loads the level-zero quantum with 10; the config port never stalls.
module mlfq_task_scheduler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mts_pkg::QUANT_W-1:0]   cfg_quantum_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mts_pkg::OP_W-1:0]      opcode_i,
  input  logic [mts_pkg::ID_W-1:0]      task_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mts_pkg::ID_W-1:0]      running_task_o,
  output logic [mts_pkg::OUT_LVL_W-1:0] running_level_o,
  output logic [mts_pkg::SLICE_W-1:0]   slices_left_o,
  output logic [mts_pkg::TICK_W-1:0]    task_ticks_o,
  output logic                          switched_o,
  output logic                          idle_o,
  output logic                          admit_error_o
);

  mts_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mts_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_we_i           (cfg_valid_i),
    .cfg_quantum_i      (cfg_quantum_i),
    .opcode_i           (opcode_i),
    .task_id_i          (task_id_i),
    .running_task_o     (running_task_o),
    .running_level_o    (running_level_o),
    .slices_left_o      (slices_left_o),
    .task_ticks_o       (task_ticks_o),
    .switched_o         (switched_o),
    .idle_o             (idle_o),
    .admit_error_o      (admit_error_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !out_valid_o || out_ready_i)
    else $error("result register loaded over a waiting beat");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> running_task_o == '0 && slices_left_o == '0 &&
                              task_ticks_o == '0 && !switched_o)
    else $error("idle result carries task data");

  a_result_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##2 !in_ready_o)
    else $error("next item accepted before result was loaded");
`endif

endmodule

>>> tb/sv/tb_mlfq_task_scheduler_top.sv
module tb_mlfq_task_scheduler_top;
  import mts_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 86;

  typedef struct packed {
    logic [ID_W-1:0]      run_id;
    logic [OUT_LVL_W-1:0] run_level;
    logic [SLICE_W-1:0]   slices;
    logic [TICK_W-1:0]    ticks;
    logic                 switched;
    logic                 idle;
    logic                 admit_err;
  } sched_status_t;

  // Shadow copy of the scheduler: per-level FIFOs, per-task bookkeeping and
  // the status each accepted beat should produce.
  class mlfq_shadow;
    logic [ID_W-1:0]    lvl_fifo [NUM_LEVELS][MAX_TASKS];
    int unsigned        head [NUM_LEVELS];
    int unsigned        count [NUM_LEVELS];
    logic [LVL_W-1:0]   t_level [MAX_TASKS];
    logic [SLICE_W-1:0] t_slices [MAX_TASKS];
    logic [TICK_W-1:0]  t_ticks [MAX_TASKS];
    bit [MAX_TASKS-1:0] active;
    int unsigned        cur;
    logic [QUANT_W-1:0] base;
    sched_status_t      status_q [$];
    int                 errors;

    function new();
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l] = 0;
        count[l] = 0;
      end
      for (int t = 0; t < MAX_TASKS; t++) begin
        t_level[t] = '0;
        t_slices[t] = '0;
        t_ticks[t] = '0;
      end
      active = '0;
      cur = 0;
      base = QUANT_RESET;
      errors = 0;
    endfunction

    function void set_quantum(logic [QUANT_W-1:0] v);
      base = v;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function logic [SLICE_W-1:0] level_quantum(int unsigned lvl);
      int unsigned q;
      q = int'(base) << lvl;
      if (q > 2047) q = 2047;
      return q[SLICE_W-1:0];
    endfunction

    function bit any_queued();
      bit b;
      b = 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) if (count[l] != 0) b = 1'b1;
      return b;
    endfunction

    function void push_tail(int unsigned lvl, int unsigned id);
      if (count[lvl] < MAX_TASKS) begin
        lvl_fifo[lvl][(head[lvl] + count[lvl]) % MAX_TASKS] = id[ID_W-1:0];
        count[lvl]++;
      end
    endfunction

    function void drop_head(int unsigned lvl);
      if (count[lvl] != 0) begin
        head[lvl] = (head[lvl] + 1) % MAX_TASKS;
        count[lvl]--;
      end
    endfunction

    function void pick_highest();
      bit found;
      found = 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (!found && count[l] != 0) begin
          cur = 32'(lvl_fifo[l][head[l]]);
          found = 1'b1;
        end
      end
    endfunction

    function void apply_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
      bit was_busy;
      bit err;
      int unsigned prev;
      int unsigned c;
      int unsigned l;
      int unsigned nl;
      sched_status_t s;
      was_busy = any_queued();
      prev = cur;
      c = cur;
      err = 1'b0;
      if (op == OP_TICK && was_busy) begin
        t_ticks[c] = t_ticks[c] + TICK_W'(1);
        if (t_slices[c] != 0) t_slices[c] = t_slices[c] - SLICE_W'(1);
        // An exhausted task drops one level, or requeues at the bottom one.
        if (t_slices[c] == 0) begin
          l = 32'(t_level[c]);
          drop_head(l);
          nl = (l + 1 < NUM_LEVELS) ? l + 1 : l;
          push_tail(nl, c);
          t_level[c] = nl[LVL_W-1:0];
          t_slices[c] = level_quantum(nl);
          pick_highest();
        end
      end else if (op == OP_YIELD && was_busy) begin
        l = 32'(t_level[c]);
        drop_head(l);
        push_tail(l, c);
        pick_highest();
      end else if (op == OP_ADMIT) begin
        if (active[id]) begin
          err = 1'b1;
        end else begin
          active[id] = 1'b1;
          t_level[id] = '0;
          t_slices[id] = level_quantum(0);
          t_ticks[id] = '0;
          push_tail(0, 32'(id));
          if (!was_busy) pick_highest();
        end
      end
      s = '0;
      if (any_queued()) begin
        s.run_id = cur[ID_W-1:0];
        s.run_level = t_level[cur];
        s.slices = t_slices[cur];
        s.ticks = t_ticks[cur];
        s.switched = !was_busy || cur != prev;
      end else begin
        s.idle = 1'b1;
      end
      s.admit_err = err;
      status_q.push_back(s);
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_status(sched_status_t act);
      sched_status_t e;
      if (status_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual task %0d",
                 $time, act.run_id);
        errors++;
      end else begin
        e = status_q.pop_front();
        compare_field("running_task", 32'(e.run_id), 32'(act.run_id));
        compare_field("running_level", 32'(e.run_level), 32'(act.run_level));
        compare_field("slices_left", 32'(e.slices), 32'(act.slices));
        compare_field("task_ticks", e.ticks, act.ticks);
        compare_field("switched", 32'(e.switched), 32'(act.switched));
        compare_field("idle", 32'(e.idle), 32'(act.idle));
        compare_field("admit_error", 32'(e.admit_err), 32'(act.admit_err));
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [QUANT_W-1:0]   cfg_quantum_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OP_W-1:0]      opcode_i;
  logic [ID_W-1:0]      task_id_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [ID_W-1:0]      running_task_o;
  logic [OUT_LVL_W-1:0] running_level_o;
  logic [SLICE_W-1:0]   slices_left_o;
  logic [TICK_W-1:0]    task_ticks_o;
  logic                 switched_o;
  logic                 idle_o;
  logic                 admit_error_o;

  mlfq_shadow shadow;
  bit         quiet;

  mlfq_task_scheduler_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_quantum_i      (cfg_quantum_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .task_id_i          (task_id_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .running_task_o     (running_task_o),
    .running_level_o    (running_level_o),
    .slices_left_o      (slices_left_o),
    .task_ticks_o       (task_ticks_o),
    .switched_o         (switched_o),
    .idle_o             (idle_o),
    .admit_error_o      (admit_error_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none at all while quiet.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
      stall = gap_len();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    sched_status_t act;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      act.run_id = running_task_o;
      act.run_level = running_level_o;
      act.slices = slices_left_o;
      act.ticks = task_ticks_o;
      act.switched = switched_o;
      act.idle = idle_o;
      act.admit_err = admit_error_o;
      shadow.check_status(act);
    end
  end

  // Called and returning on a falling edge; valid stays up across back-to-back beats.
  task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    task_id_i <= id;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    shadow.apply_item(op, id);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_quantum(logic [QUANT_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_quantum_i <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    shadow.set_quantum(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random();
    int r;
    logic [ID_W-1:0] id;
    r = $urandom_range(0, 99);
    id = ID_W'($urandom_range(0, MAX_TASKS - 1));
    if (r < 55) send_item(OP_TICK, id);
    else if (r < 75) send_item(OP_YIELD, id);
    else if (r < 93) send_item(OP_ADMIT, id);
    else send_item(OP_NONE, id);
  endtask

  initial begin
    logic [QUANT_W-1:0] q;
    shadow = new();
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_quantum_i = '0;
    in_valid_i = 1'b0;
    opcode_i = OP_TICK;
    task_id_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Nothing queued yet: tick, yield and the unused opcode all report idle.
    send_item(OP_TICK, 4'd3);
    send_item(OP_YIELD, 4'd12);
    send_item(OP_NONE, 4'd0);
    // The first admit runs at once; later admits never preempt.
    send_item(OP_ADMIT, 4'd0);
    send_item(OP_ADMIT, 4'd0);
    send_item(OP_ADMIT, 4'd15);
    send_item(OP_NONE, 4'd15);
    send_item(OP_YIELD, 4'd0);
    // Run the new head out of its quantum so it drops a level.
    repeat (10) send_item(OP_TICK, 4'd9);

    // A zero quantum: tasks start with no slices, yield without demotion and
    // expire on their first tick.
    drain();
    write_quantum(8'd0);
    send_item(OP_ADMIT, 4'd1);
    send_item(OP_YIELD, 4'd0);
    send_item(OP_YIELD, 4'd0);
    send_item(OP_YIELD, 4'd0);
    send_item(OP_TICK, 4'd0);

    drain();
    write_quantum(8'd255);
    send_item(OP_ADMIT, 4'd2);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: q = 8'd1;
        1: q = 8'd2;
        2: q = 8'd0;
        3: q = 8'd255;
        4: q = QUANT_W'($urandom_range(1, 254));
        5: q = 8'd3;
        default: q = 8'd1;
      endcase
      drain();
      write_quantum(q);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_random();
    end

    drain();
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> mlfq_task_scheduler_top.f
rtl/mts_pkg.sv
rtl/mts_ctrl.sv
rtl/mts_dp.sv
rtl/mlfq_task_scheduler_top.sv
tb/sv/tb_mlfq_task_scheduler_top.sv
